### hw/rtl/ledc_pkg.sv
// shared types, register codes and frame constants of the led controller register device
// no dependencies; imported by ledc_frame_check, ledc_status_read and the top level

package ledc_pkg;

    localparam int NUM_LEDS  = 4;
    localparam int LED_W     = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int FRAME_LEN = 12;

    localparam logic [7:0]  SIG_REG     = 8'h5a;
    localparam logic [7:0]  FLAG_REG    = 8'h80;
    localparam logic [7:0]  STATUS_BASE = 8'h81;
    localparam logic [15:0] SIGNATURE   = 16'hc5b2;

    localparam logic [3:0] COUNT_MAX     = 4'hf;
    localparam logic [3:0] FRAME_LEN_CNT = 4'(FRAME_LEN);
    localparam logic [3:0] STATUS_LAST   = 4'hb - 4'h1;

    // frame commands
    localparam logic [7:0] CMD_BRIGHT = 8'h01;
    localparam logic [7:0] CMD_COLOUR = 8'h02;
    localparam logic [7:0] CMD_ONOFF  = 8'h03;
    localparam logic [7:0] CMD_BLINK  = 8'h04;
    localparam logic [7:0] CMD_BREATH = 8'h05;

    localparam logic [1:0] MODE_BLINK  = 2'd2;
    localparam logic [1:0] MODE_BREATH = 2'd3;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_STOP  = 2'd2
    } op_t;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  brightness;
        logic [23:0] colour;
        logic [15:0] period_total;
        logic [15:0] period_on;
    } led_state_t;

    typedef struct packed {
        logic  valid;
        byte_t cmd;
        byte_t p0;
        byte_t p1;
        byte_t p2;
        byte_t p3;
    } frame_info_t;

endpackage

### hw/rtl/ledc_frame_check.sv
// checksum and command check of a buffered 12-byte write frame
// depends on ledc_pkg

module ledc_frame_check (
    input  logic [ledc_pkg::FRAME_LEN-1:0][7:0] frame_i,
    output ledc_pkg::frame_info_t              info_o
);
    import ledc_pkg::*;

    logic [11:0] sum;
    logic [15:0] check;
    logic        cmd_ok;

    // byte 0 is not summed
    always_comb begin
        sum = '0;
        for (int i = 1; i < 10; i++) begin
            sum = sum + {4'b0, frame_i[i]};
        end
    end

    assign check = {frame_i[10], frame_i[11]};

    always_comb begin
        unique case (frame_i[5])
            CMD_BRIGHT, CMD_COLOUR, CMD_BLINK, CMD_BREATH: begin
                cmd_ok = 1'b1;
            end
            CMD_ONOFF: begin
                cmd_ok = (frame_i[6] < 8'd2);
            end
            default: begin
                cmd_ok = 1'b0;
            end
        endcase
    end

    assign info_o.valid = cmd_ok && ({4'b0, sum} == check);
    assign info_o.cmd   = frame_i[5];
    assign info_o.p0    = frame_i[6];
    assign info_o.p1    = frame_i[7];
    assign info_o.p2    = frame_i[8];
    assign info_o.p3    = frame_i[9];

endmodule

### hw/rtl/ledc_status_read.sv
// byte select from the 11-byte status record of one led, checksum included
// depends on ledc_pkg

module ledc_status_read (
    input  ledc_pkg::led_state_t led_i,
    input  logic [3:0]           idx_i,
    output ledc_pkg::byte_t      byte_o
);
    import ledc_pkg::*;

    byte_t       rec [9];
    logic [11:0] sum;

    always_comb begin
        rec[0] = {6'b0, led_i.mode};
        rec[1] = led_i.brightness;
        rec[2] = led_i.colour[23:16];
        rec[3] = led_i.colour[15:8];
        rec[4] = led_i.colour[7:0];
        rec[5] = led_i.period_total[15:8];
        rec[6] = led_i.period_total[7:0];
        rec[7] = led_i.period_on[15:8];
        rec[8] = led_i.period_on[7:0];
    end

    always_comb begin
        sum = '0;
        for (int i = 0; i < 9; i++) begin
            sum = sum + {4'b0, rec[i]};
        end
    end

    always_comb begin
        if (idx_i < 4'd9) begin
            byte_o = rec[idx_i];
        end else if (idx_i == STATUS_LAST - 4'd1) begin
            byte_o = {4'b0, sum[11:8]};
        end else if (idx_i == STATUS_LAST) begin
            byte_o = sum[7:0];
        end else begin
            byte_o = '0;
        end
    end

endmodule

### hw/rtl/led_controller_register_device.sv
// top level of the led controller register device: smbus byte events in, one result word out
// depends on ledc_pkg, ledc_frame_check and ledc_status_read
//
//  channel | direction | tdata (lsb first)                          | tuser
//  s_      | in        | reg_addr[7:0] byte_index[11:8] write_byte[19:12] | opcode[1:0]
//  m_      | out       | read_data[7:0] frame_accepted[8]           | -
//
// one event per cycle sustained while m_tready is high; each event passes through the input
// register into the result register, which holds its result word.
// the result register stalls on m_tready and the input register fills behind it; s_tready
// drops only while both hold a word.
// aresetn clears led state, byte count and the success flag; the frame buffer is not reset.

module led_controller_register_device (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // reg_addr, byte_index, write_byte, zero pad
    input  logic [1:0]  s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // read_data, frame_accepted, zero pad
);
    import ledc_pkg::*;

    // input register
    logic       in_valid_reg;
    logic [1:0] in_op_reg;
    byte_t      in_addr_reg;
    logic [3:0] in_idx_reg;
    byte_t      in_byte_reg;

    // result register
    logic       out_valid_reg;
    byte_t      out_rd_reg;
    logic       out_acc_reg;

    // block state
    logic [FRAME_LEN-1:0][7:0] frame_reg, frame_next;
    logic [3:0]                count_reg, count_next;
    led_state_t                led_reg  [NUM_LEDS];
    led_state_t                led_next [NUM_LEDS];
    logic                      ok_reg, ok_next;

    logic        advance;
    logic        fire;
    frame_info_t info;
    logic        led_hit;
    logic [LED_W-1:0] led_sel;
    logic        status_hit;
    byte_t       status_off;
    byte_t       status_byte;
    byte_t       rd;
    logic        acc;
    logic        frame_good;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign fire     = in_valid_reg && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg   <= s_tuser;
            in_addr_reg <= s_tdata[7:0];
            in_idx_reg  <= s_tdata[11:8];
            in_byte_reg <= s_tdata[19:12];
        end
    end

    ledc_frame_check u_frame_check (
        .frame_i (frame_reg),
        .info_o  (info)
    );

    assign led_hit = (in_addr_reg < 8'(NUM_LEDS));
    assign led_sel = in_addr_reg[LED_W-1:0];

    assign status_off = in_addr_reg - STATUS_BASE;
    assign status_hit = (in_addr_reg >= STATUS_BASE) && (status_off < 8'(NUM_LEDS));

    ledc_status_read u_status_read (
        .led_i  (led_reg[status_off[LED_W-1:0]]),
        .idx_i  (in_idx_reg),
        .byte_o (status_byte)
    );

    assign frame_good = (count_reg == FRAME_LEN_CNT) && led_hit && info.valid;

    always_comb begin
        frame_next = frame_reg;
        count_next = count_reg;
        led_next   = led_reg;
        ok_next    = ok_reg;
        rd         = '0;
        acc        = 1'b0;
        if (fire) begin
            case (in_op_reg)
                OP_WRITE: begin
                    // bytes past the frame are counted but dropped
                    if (in_idx_reg < FRAME_LEN_CNT) begin
                        frame_next[in_idx_reg] = in_byte_reg;
                    end
                    if (count_reg != COUNT_MAX) begin
                        count_next = count_reg + 4'd1;
                    end
                end
                OP_READ: begin
                    if (in_addr_reg == FLAG_REG) begin
                        rd = (in_idx_reg == 4'd0) ? {7'b0, ok_reg} : '0;
                    end else if (in_addr_reg == SIG_REG) begin
                        if (in_idx_reg == 4'd0) begin
                            rd = SIGNATURE[7:0];
                        end else if (in_idx_reg == 4'd1) begin
                            rd = SIGNATURE[15:8];
                        end
                    end else if (status_hit) begin
                        rd = status_byte;
                    end
                end
                OP_STOP: begin
                    // a stop with no write bytes leaves the flag alone
                    if (count_reg != 4'd0) begin
                        acc     = frame_good;
                        ok_next = frame_good;
                        if (frame_good) begin
                            case (info.cmd)
                                CMD_BRIGHT: begin
                                    led_next[led_sel].brightness = info.p0;
                                end
                                CMD_COLOUR: begin
                                    led_next[led_sel].colour = {info.p0, info.p1, info.p2};
                                end
                                CMD_ONOFF: begin
                                    led_next[led_sel].mode = info.p0[1:0];
                                end
                                CMD_BLINK, CMD_BREATH: begin
                                    led_next[led_sel].period_total = {info.p0, info.p1};
                                    led_next[led_sel].period_on    = {info.p2, info.p3};
                                    led_next[led_sel].mode =
                                        (info.cmd == CMD_BLINK) ? MODE_BLINK : MODE_BREATH;
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                    count_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        frame_reg <= frame_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ok_reg    <= 1'b0;
            for (int i = 0; i < NUM_LEDS; i++) begin
                led_reg[i] <= '0;
            end
        end else begin
            count_reg <= count_next;
            ok_reg    <= ok_next;
            led_reg   <= led_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_rd_reg  <= rd;
            out_acc_reg <= acc;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_acc_reg, out_rd_reg};

endmodule

### hw/rtl/ledc_checker.sv
// port-level checks of the led controller register device, bound to the top level
// depends on led_controller_register_device

module ledc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // no result word right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // an empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // a stop never returns read data, a read never accepts a frame
    a_acc_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |-> (m_tdata[7:0] == 8'h00))
        else $error("frame accept with nonzero read data");

    // pad bits stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:9] == 7'h00))
        else $error("nonzero pad in result word");

endmodule

bind led_controller_register_device ledc_checker u_ledc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
